// ===== rtl/core/rdpp_pkg.sv =====
`timescale 1ns / 1ps

package rdpp_pkg;

    // Request codes
    localparam logic REQ_PLOT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Rotation codes, clockwise
    localparam logic [1:0] ROT_NONE    = 2'd0;
    localparam logic [1:0] ROT_QUARTER = 2'd1;
    localparam logic [1:0] ROT_HALF    = 2'd2;
    localparam logic [1:0] ROT_THREEQ  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROTATION = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;

    // Field widths fixed by the interface
    localparam int CFG_DATA_W  = 9;
    localparam int WIDTH_W     = 10;   // rounded width reaches 512
    localparam int HEIGHT_W    = 9;
    localparam int LPOS_W      = 9;    // clipped logical coordinate
    localparam int PIX_ADDR_W  = 18;   // largest byte address a plot can form
    localparam int READ_ADDR_W = 13;

    // Reset values of the registers
    localparam logic [1:0]          ROTATION_RST = ROT_NONE;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 10'd8;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 9'd1;

    // Colour bit positions: TL, TR, BL, BR per plane
    localparam int COL_BLK_TL = 6;
    localparam int COL_BLK_TR = 4;
    localparam int COL_BLK_BL = 2;
    localparam int COL_BLK_BR = 0;
    localparam int COL_RED_TL = 7;
    localparam int COL_RED_TR = 5;
    localparam int COL_RED_BL = 3;
    localparam int COL_RED_BR = 1;

    // Leftmost two pixels of a byte
    localparam logic [7:0] PAIR_MASK_LEFT = 8'hC0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ADDR,
        ST_RD_TOP,
        ST_RD_BOT,
        ST_WR_BOT,
        ST_READ,
        ST_DONE
    } rdpp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic clip_en;
        logic addr_en;
        logic rd_top;
        logic rd_bot;
        logic wr_top;
        logic wr_bot;
        logic rd_req;
        logic load_out;
    } rdpp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
        logic in_area;
    } rdpp_status_t;

endpackage

// ===== rtl/core/rdpp_ctrl.sv =====
`timescale 1ns / 1ps

module rdpp_ctrl
    import rdpp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  rdpp_status_t status,
    output rdpp_cmd_t    cmd
);

    rdpp_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    // Output register may be loaded when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CLIP;
            end
            ST_CLIP: begin
                state_next = status.is_read ? ST_READ : ST_ADDR;
            end
            ST_ADDR: begin
                state_next = status.in_area ? ST_RD_TOP : ST_DONE;
            end
            ST_RD_TOP: state_next = ST_RD_BOT;
            ST_RD_BOT: state_next = ST_WR_BOT;
            ST_WR_BOT: state_next = ST_DONE;
            ST_READ:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.load_in  = s_valid;
            ST_CLIP:   cmd.clip_en  = 1'b1;
            ST_ADDR:   cmd.addr_en  = 1'b1;
            ST_RD_TOP: cmd.rd_top   = 1'b1;
            ST_RD_BOT: begin
                cmd.rd_bot = 1'b1;
                cmd.wr_top = 1'b1;
            end
            ST_WR_BOT: cmd.wr_bot   = 1'b1;
            ST_READ:   cmd.rd_req   = 1'b1;
            ST_DONE:   cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    // Set valid on load, drop it after the transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/rdpp_datapath.sv =====
`timescale 1ns / 1ps

module rdpp_datapath
    import rdpp_pkg::*;
#(
    parameter int PLANE_BYTES = 8192,
    parameter int COORD_BITS  = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_req_type,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic [7:0]                   s_colour_code,
    input  logic [READ_ADDR_W-1:0]       s_read_address,
    output logic [7:0]                   m_black_byte,
    output logic [7:0]                   m_red_byte,
    output logic                         m_drawn,
    input  rdpp_cmd_t                    cmd,
    output rdpp_status_t                 status
);

    localparam int ADDR_W = $clog2(PLANE_BYTES);
    localparam int SUM_W  = ((COORD_BITS > WIDTH_W) ? COORD_BITS : WIDTH_W) + 2;
    localparam logic [PIX_ADDR_W:0] ADDR_LIMIT = (PIX_ADDR_W + 1)'(PLANE_BYTES);

    // Configuration registers
    logic [1:0]          rotation_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_round;

    // Latched request
    logic                         req_type_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [7:0]                   colour_reg;
    logic [READ_ADDR_W-1:0]       raddr_reg;

    // Rotated and clipped coordinate
    logic signed [SUM_W-1:0] x_s, y_s, w_s, h_s, rx_s, ry_s;
    logic                    inside_c;
    logic [LPOS_W-1:0]       rx_reg, ry_reg;
    logic                    inside_reg;

    // Byte addresses
    logic [PIX_ADDR_W-1:0] row_base;
    logic [PIX_ADDR_W-1:0] top_reg, bot_reg;
    logic                  top_ok, bot_ok, raddr_ok;

    // Both planes in one word: black high, red low
    logic [15:0]       mem [PLANE_BYTES];
    logic [15:0]       rdata_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_idx, wr_idx;
    logic [15:0]       wdata;
    logic [7:0]        pair_mask;
    logic [2:0]        pair_shift;
    logic [7:0]        blk_bits, red_bits;

    // Output register payload
    logic [7:0] black_out_reg, red_out_reg;
    logic       drawn_out_reg;

    // Round the width up to a multiple of eight
    assign width_round = ({1'b0, cfg_wdata} + WIDTH_W'(7)) & ~WIDTH_W'(7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= ROTATION_RST;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROTATION: rotation_reg <= cfg_wdata[1:0];
                CFG_WIDTH:    width_reg    <= width_round;
                CFG_HEIGHT:   height_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Hold the request payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_type_reg <= s_req_type;
            x_reg        <= s_pos_x;
            y_reg        <= s_pos_y;
            colour_reg   <= s_colour_code;
            raddr_reg    <= s_read_address;
        end
    end

    // Rotate clockwise, then clip to the logical area
    assign x_s = SUM_W'(x_reg);
    assign y_s = SUM_W'(y_reg);
    assign w_s = signed'(SUM_W'(width_reg));
    assign h_s = signed'(SUM_W'(height_reg));

    always_comb begin
        unique case (rotation_reg)
            ROT_NONE: begin
                rx_s = x_s;
                ry_s = y_s;
            end
            ROT_QUARTER: begin
                rx_s = w_s - y_s;
                ry_s = x_s;
            end
            ROT_HALF: begin
                rx_s = w_s - x_s;
                ry_s = h_s - y_s;
            end
            ROT_THREEQ: begin
                rx_s = y_s;
                ry_s = h_s - x_s;
            end
            default: begin
                rx_s = x_s;
                ry_s = y_s;
            end
        endcase
    end

    assign inside_c = (rx_s >= 0) && (rx_s < w_s) && (ry_s >= 0) && (ry_s < h_s);

    always_ff @(posedge aclk) begin
        if (cmd.clip_en) begin
            rx_reg     <= rx_s[LPOS_W-1:0];
            ry_reg     <= ry_s[LPOS_W-1:0];
            inside_reg <= inside_c;
        end
    end

    // Top byte: row * width/2 + column/4; bottom byte one physical row later
    assign row_base = PIX_ADDR_W'(ry_reg) * PIX_ADDR_W'(width_reg[WIDTH_W-1:1]);

    always_ff @(posedge aclk) begin
        if (cmd.addr_en) begin
            top_reg <= row_base + PIX_ADDR_W'(rx_reg[LPOS_W-1:2]);
        end
        if (cmd.rd_top) begin
            bot_reg <= top_reg + PIX_ADDR_W'(width_reg[WIDTH_W-1:2]);
        end
    end

    assign top_ok   = {1'b0, top_reg} < ADDR_LIMIT;
    assign bot_ok   = {1'b0, bot_reg} < ADDR_LIMIT;
    assign raddr_ok = (PIX_ADDR_W + 1)'(raddr_reg) < ADDR_LIMIT;

    // Read port address select
    always_comb begin
        rd_en  = cmd.rd_top || cmd.rd_bot || cmd.rd_req;
        rd_idx = top_reg[ADDR_W-1:0];
        priority if (cmd.rd_bot) begin
            rd_idx = bot_reg[ADDR_W-1:0];
        end else if (cmd.rd_req) begin
            rd_idx = ADDR_W'(PIX_ADDR_W'(raddr_reg));
        end else begin
            rd_idx = top_reg[ADDR_W-1:0];
        end
    end

    // Merge the pixel pair into the byte just read
    assign pair_shift = {rx_reg[1:0], 1'b0};
    assign pair_mask  = PAIR_MASK_LEFT >> pair_shift;

    always_comb begin
        if (cmd.wr_top) begin
            blk_bits = {colour_reg[COL_BLK_TL], colour_reg[COL_BLK_TR], 6'b0} >> pair_shift;
            red_bits = {colour_reg[COL_RED_TL], colour_reg[COL_RED_TR], 6'b0} >> pair_shift;
            wr_en    = top_ok;
            wr_idx   = top_reg[ADDR_W-1:0];
        end else begin
            blk_bits = {colour_reg[COL_BLK_BL], colour_reg[COL_BLK_BR], 6'b0} >> pair_shift;
            red_bits = {colour_reg[COL_RED_BL], colour_reg[COL_RED_BR], 6'b0} >> pair_shift;
            wr_en    = cmd.wr_bot && bot_ok;
            wr_idx   = bot_reg[ADDR_W-1:0];
        end
        wdata = {(rdata_reg[15:8] & ~pair_mask) | blk_bits,
                 (rdata_reg[7:0]  & ~pair_mask) | red_bits};
    end

    // Plane memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_idx];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (req_type_reg == REQ_READ && raddr_ok) begin
                black_out_reg <= rdata_reg[15:8];
                red_out_reg   <= rdata_reg[7:0];
            end else begin
                black_out_reg <= 8'h00;
                red_out_reg   <= 8'h00;
            end
            drawn_out_reg <= (req_type_reg == REQ_PLOT) && inside_reg;
        end
    end

    assign m_black_byte   = black_out_reg;
    assign m_red_byte     = red_out_reg;
    assign m_drawn        = drawn_out_reg;
    assign status.is_read = (req_type_reg == REQ_READ);
    assign status.in_area = inside_reg;

endmodule

// ===== rtl/core/rotated_doubled_pixel_plotter.sv =====
`timescale 1ns / 1ps

// Two-plane (black, red) 1-bit-per-pixel frame store. A plot request rotates
// its logical (x, y) clockwise by the rotation register, clips it to the
// logical area and writes a 2x2 block of physical pixels in both planes by
// read-modify-write of two bytes; a read request returns one byte of each
// plane. One request is in work at a time: an unclipped plot passes through the
// rotate/clip and address stages and then the serial read then write of the top
// and bottom bytes through the single read and write port of the plane memory; a
// clipped plot stops after the address stage and a read after one memory read.
// The input is taken again while a result still waits in the output register.
// The planes are not cleared by reset; bytes never written read back as unknown.
module rotated_doubled_pixel_plotter
    import rdpp_pkg::*;
#(
    parameter int PLANE_BYTES = 8192,
    parameter int COORD_BITS  = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic [7:0]                   s_colour_code,
    input  logic [READ_ADDR_W-1:0]       s_read_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_black_byte,
    output logic [7:0]                   m_red_byte,
    output logic                         m_drawn
);

    rdpp_cmd_t    cmd;
    rdpp_status_t status;

    // Sequence the request
    rdpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Rotate, address and update the planes
    rdpp_datapath #(
        .PLANE_BYTES (PLANE_BYTES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_colour_code  (s_colour_code),
        .s_read_address (s_read_address),
        .m_black_byte   (m_black_byte),
        .m_red_byte     (m_red_byte),
        .m_drawn        (m_drawn),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ===== tb/sv/pixel_plane_checker.sv =====
`timescale 1ns / 1ps

module pixel_plane_checker
    import rdpp_pkg::*;
#(
    parameter int PLANE_BYTES = 8192,
    parameter int COORD_BITS  = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_req_type,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic [7:0]                   s_colour_code,
    input  logic [READ_ADDR_W-1:0]       s_read_address,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [7:0]                   m_black_byte,
    input  logic [7:0]                   m_red_byte,
    input  logic                         m_drawn,
    output int                           outstanding,
    output int                           mismatches
);

    typedef struct packed {
        logic [7:0] black;
        logic [7:0] red;
        logic       drawn;
    } plane_reply_t;

    // Shadow copy of both planes and of the geometry registers
    bit   [7:0]          black_bytes [PLANE_BYTES];
    bit   [7:0]          red_bytes   [PLANE_BYTES];
    logic [1:0]          rotation_q;
    logic [WIDTH_W-1:0]  width_q;
    logic [HEIGHT_W-1:0] height_q;

    plane_reply_t reply_queue [$];
    int           err_count = 0;
    int           shown     = 0;

    // Set or clear one pixel bit in both planes; drop bytes past the store
    task automatic paint_byte(input int addr, input logic [7:0] mask,
                              input logic blk_on, input logic red_on);
        if (addr < PLANE_BYTES) begin
            black_bytes[addr] = blk_on ? (black_bytes[addr] | mask)
                                       : (black_bytes[addr] & ~mask);
            red_bytes[addr]   = red_on ? (red_bytes[addr] | mask)
                                       : (red_bytes[addr] & ~mask);
        end
    endtask

    // Work out the reply of one request and update the shadow planes
    task automatic compute_reply(input logic req,
                                 input logic signed [COORD_BITS-1:0] col_in, row_in,
                                 input logic [7:0] colour,
                                 input logic [READ_ADDR_W-1:0] addr,
                                 output plane_reply_t reply);
        int x, y, w, h, rx, ry;
        int phx, phy, row_bits, top, bot;
        logic [7:0] mask_l, mask_r;
        reply = '0;
        if (req == REQ_READ) begin
            if (addr < PLANE_BYTES) begin
                reply.black = black_bytes[addr];
                reply.red   = red_bytes[addr];
            end
        end else begin
            x  = col_in;
            y  = row_in;
            w  = width_q;
            h  = height_q;
            rx = x;
            ry = y;
            // Clockwise rotation, no minus-one offset
            case (rotation_q)
                ROT_QUARTER: begin
                    rx = w - y;
                    ry = x;
                end
                ROT_HALF: begin
                    rx = w - x;
                    ry = h - y;
                end
                ROT_THREEQ: begin
                    rx = y;
                    ry = h - x;
                end
                default: ;
            endcase
            // Clip to the logical area, then write the 2x2 block
            if (rx >= 0 && rx < w && ry >= 0 && ry < h) begin
                phx      = 2 * rx;
                phy      = 2 * ry;
                row_bits = 2 * w;
                top      = (phx + phy * row_bits) / 8;
                bot      = (phx + (phy + 1) * row_bits) / 8;
                mask_l   = 8'h80 >> (phx % 8);
                mask_r   = 8'h80 >> ((phx + 1) % 8);
                paint_byte(top, mask_l, colour[COL_BLK_TL], colour[COL_RED_TL]);
                paint_byte(top, mask_r, colour[COL_BLK_TR], colour[COL_RED_TR]);
                paint_byte(bot, mask_l, colour[COL_BLK_BL], colour[COL_RED_BL]);
                paint_byte(bot, mask_r, colour[COL_BLK_BR], colour[COL_RED_BR]);
                reply.drawn = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        plane_reply_t want;
        plane_reply_t got;
        if (!aresetn) begin
            rotation_q = ROTATION_RST;
            width_q    = WIDTH_RST;
            height_q   = HEIGHT_RST;
            reply_queue.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROTATION: rotation_q = cfg_wdata[1:0];
                    CFG_WIDTH:    width_q    = ({1'b0, cfg_wdata} + 10'd7) & 10'h3F8;
                    CFG_HEIGHT:   height_q   = cfg_wdata;
                    default: ;
                endcase
            end

            // Predict on each input transfer
            if (s_valid && s_ready) begin
                compute_reply(s_req_type, s_pos_x, s_pos_y, s_colour_code,
                              s_read_address, want);
                reply_queue.push_back(want);
            end

            // Compare each output transfer with the oldest prediction
            if (m_valid && m_ready) begin
                got.black = m_black_byte;
                got.red   = m_red_byte;
                got.drawn = m_drawn;
                if (reply_queue.size() == 0) begin
                    err_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("unexpected reply: black %02h red %02h drawn %0b",
                                 got.black, got.red, got.drawn);
                    end
                end else begin
                    want = reply_queue.pop_front();
                    if (got.black !== want.black || got.red !== want.red ||
                        got.drawn !== want.drawn) begin
                        err_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("reply mismatch: black exp %02h got %02h, red exp %02h got %02h, drawn exp %0b got %0b",
                                     want.black, got.black, want.red, got.red,
                                     want.drawn, got.drawn);
                        end
                    end
                end
            end

            outstanding <= reply_queue.size();
            mismatches  <= err_count;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rdpp_pkg::*;

    localparam int PLANE_BYTES = 8192;
    localparam int COORD_BITS  = 11;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 26;
    localparam int PAINT_BYTES = 128;

    // Index past the register list; a write there must do nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         cfg_wr_en      = 1'b0;
    logic [1:0]                   cfg_index      = CFG_ROTATION;
    logic [CFG_DATA_W-1:0]        cfg_wdata      = '0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic                         s_req_type     = REQ_PLOT;
    logic signed [COORD_BITS-1:0] s_pos_x        = '0;
    logic signed [COORD_BITS-1:0] s_pos_y        = '0;
    logic [7:0]                   s_colour_code  = '0;
    logic [READ_ADDR_W-1:0]       s_read_address = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic [7:0]                   m_black_byte;
    logic [7:0]                   m_red_byte;
    logic                         m_drawn;

    int   outstanding;
    int   mismatches;
    logic idle_on    = 1'b1;
    int   stall_left = 0;
    int   cycles     = 0;
    int   cur_w      = 8;
    int   cur_h      = 1;

    rotated_doubled_pixel_plotter #(
        .PLANE_BYTES (PLANE_BYTES),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_colour_code  (s_colour_code),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_black_byte   (m_black_byte),
        .m_red_byte     (m_red_byte),
        .m_drawn        (m_drawn)
    );

    pixel_plane_checker #(
        .PLANE_BYTES (PLANE_BYTES),
        .COORD_BITS  (COORD_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_colour_code  (s_colour_code),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_black_byte   (m_black_byte),
        .m_red_byte     (m_red_byte),
        .m_drawn        (m_drawn),
        .outstanding    (outstanding),
        .mismatches     (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side at random in bursts while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("rotated_doubled_pixel_plotter verification failed");
            $finish;
        end
    end

    // Present one request and hold it until the transfer
    task automatic send_request(input logic req, input int x, input int y,
                                input int colour, input int addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_pos_x        <= x[COORD_BITS-1:0];
        s_pos_y        <= y[COORD_BITS-1:0];
        s_colour_code  <= colour[7:0];
        s_read_address <= addr[READ_ADDR_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_plot(input int x, input int y, input int colour);
        send_request(REQ_PLOT, x, y, colour, $urandom_range(0, PLANE_BYTES - 1));
    endtask

    task automatic send_read(input int addr);
        send_request(REQ_READ, $urandom_range(0, 2047) - 1024,
                     $urandom_range(0, 2047) - 1024, $urandom_range(0, 255), addr);
    endtask

    // Drop valid and wait until every reply is back and the block is idle
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int rot, input int w, input int h);
        quiesce();
        write_reg(CFG_ROTATION, rot);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        cur_w = ((w % 512) + 7) / 8 * 8;
        cur_h = h % 512;
    endtask

    initial begin
        int phase_rot [8];
        int phase_w   [8];
        int phase_h   [8];
        int x;
        int y;
        int lim;
        int sel;
        phase_rot = '{ROT_HALF, ROT_QUARTER, ROT_THREEQ, ROT_NONE,
                      ROT_QUARTER, ROT_THREEQ, ROT_HALF, ROT_NONE};
        phase_w   = '{505, 255, 0, 16, 1, 511, 100, 256};
        phase_h   = '{256, 200, 10, 0, 3, 511, 37, 64};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry is 8 x 1
        write_reg(CFG_SPARE, $urandom_range(0, 511));
        send_plot(0, 0, 8'hFF);
        send_plot(7, 0, 8'h00);
        send_plot(8, 0, 8'h5A);
        send_plot(3, 1, 8'hA5);

        // Paint the low bytes of the store; reads stay within painted bytes
        set_geometry(ROT_NONE, 32, 8);
        for (y = 0; y < 8; y++) begin
            for (x = 0; x < 32; x++) send_plot(x, y, $urandom_range(0, 255));
        end

        // Paint the last two bytes that the 256 x 64 raster reaches
        set_geometry(ROT_NONE, 256, 64);
        for (x = 252; x < 256; x++) send_plot(x, 63, $urandom_range(0, 255));

        // Address extremes and alternating bits
        send_read(0);
        send_read(PLANE_BYTES - 1);
        send_read(PAINT_BYTES - 1);
        send_read(8127);
        send_read(8'h55);
        send_read(8'h2A);
        // Corners, clip edges and coordinate extremes, then read back
        send_plot(0, 0, 8'hFF);
        send_plot(255, 63, 8'h00);
        send_plot(-1, 0, 8'hAA);
        send_plot(256, 0, 8'h55);
        send_plot(0, 64, 8'hFF);
        send_plot(0, -1, 8'hFF);
        send_plot(-1024, -1024, 8'hFF);
        send_plot(1023, 1023, 8'hFF);
        send_plot(5, 0, 8'hA5);
        send_read(1);
        send_read(65);
        send_read(8127);
        send_read(0);

        // Rotations: the edge one past the last column or row clips
        set_geometry(ROT_QUARTER, 256, 64);
        send_plot(0, 0, 8'hC3);
        send_plot(0, 1, 8'h3C);
        send_plot(63, 256, 8'h96);
        set_geometry(ROT_HALF, 256, 64);
        send_plot(0, 0, 8'h69);
        send_plot(1, 1, 8'hF0);
        set_geometry(ROT_THREEQ, 256, 64);
        send_plot(0, 0, 8'h0F);
        send_plot(1, 0, 8'h81);

        // Random phases over a spread of geometries
        for (int p = 0; p < PHASES; p++) begin
            idle_on <= (p != PHASES - 1) && (p % 3 != 2);
            if (p < 8) begin
                set_geometry(phase_rot[p], phase_w[p], phase_h[p]);
            end else begin
                set_geometry($urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 511));
                write_reg(CFG_SPARE, $urandom_range(0, 511));
            end
            lim = (cur_w > cur_h) ? cur_w : cur_h;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold off the sender until the pipeline has drained
                if ((p == 3 || p == 6) && i == 13) quiesce();
                sel = $urandom_range(0, 9);
                if (sel < 3) begin
                    send_read(($urandom_range(0, 7) == 0) ? (PLANE_BYTES - 1)
                                                          : $urandom_range(0, PAINT_BYTES - 1));
                end else if (sel < 5) begin
                    send_plot($urandom_range(0, 2047) - 1024,
                              $urandom_range(0, 2047) - 1024, $urandom_range(0, 255));
                end else begin
                    send_plot($urandom_range(0, lim + 3) - 2,
                              $urandom_range(0, lim + 3) - 2, $urandom_range(0, 255));
                end
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("rotated_doubled_pixel_plotter verification clean");
        end else begin
            $display("rotated_doubled_pixel_plotter verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rdpp_pkg.sv
rtl/core/rdpp_ctrl.sv
rtl/core/rdpp_datapath.sv
rtl/core/rotated_doubled_pixel_plotter.sv
tb/sv/pixel_plane_checker.sv
tb/sv/tb_top.sv
